### design/rmvmm_pkg.sv
// Shared types and constants for the running mean / variance / min / max unit.
// No dependencies.
`default_nettype none
package rmvmm_pkg;

  localparam int SampleBits = 16;
  localparam int CountBits  = 32;
  localparam int FracBits   = 16;
  localparam int MeanBits   = 32;
  localparam int VarBits    = 48;
  // var + mean^2 term, times count, plus x^2 * S
  localparam int AccBits    = 49;
  localparam int SumBits    = 82;
  localparam int RemBits    = CountBits;
  localparam int StepBits   = 7;
  localparam int MeanDivLen = MeanBits + 1;

  localparam logic [StepBits-1:0] MeanSteps = StepBits'(MeanDivLen);
  localparam logic [StepBits-1:0] VarSteps  = StepBits'(SumBits);
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [VarBits-1:0]   VarMax   = {VarBits{1'b1}};

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_MO,
    OP_SQ_X,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ACC_HI,
    OP_DIV_MEAN,
    OP_MEAN,
    OP_SQ_MN,
    OP_DIV_VAR,
    OP_COMMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_MO,
    ST_SQ_X,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC_HI,
    ST_DIVM_START,
    ST_DIVM_WAIT,
    ST_MEAN,
    ST_SQ_MN,
    ST_DIVV_START,
    ST_DIVV_WAIT,
    ST_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   in_ready;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

### design/running_mean_variance_min_max_unit.sv
// Top level of the running mean / variance / min / max unit.
// Uses rmvmm_pkg, rmvmm_ctrl and rmvmm_dp.
//
// Usage:
//   s_axis carries one signed 16-bit sample per item. m_axis returns one
//   result item per sample: count, mean (16 fraction bits), population
//   variance (16 fraction bits), minimum and maximum since reset.
//   One item is worked on at a time. After acceptance the controller runs
//   multiply/accumulate steps on the shared 32x32 multiplier, a 33-step
//   division for the mean and an 82-step division for the variance on the
//   shared one-bit-per-cycle divider, and then commits the result. The
//   next item is taken only after the commit, back in the idle state.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver stalls, the following result holds in the
//   commit step until the register frees, and no further item is taken.
//   Reset (rst_ni low, asynchronous) clears count, mean and variance, sets
//   the minimum to 32767 and the maximum to -32768, and drops m_axis_tvalid.
`default_nettype none
module running_mean_variance_min_max_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [15:0]  s_axis_tdata,   // [15:0] sample
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] sample_count, [63:32] mean_value, [111:64] variance_value,
  // [127:112] min_value, [143:128] max_value
  output logic [143:0]      m_axis_tdata
);

  rmvmm_pkg::dp_cmd_t    cmd;
  rmvmm_pkg::dp_status_t status;
  logic [rmvmm_pkg::CountBits-1:0]  o_count;
  logic [rmvmm_pkg::MeanBits-1:0]   o_mean;
  logic [rmvmm_pkg::VarBits-1:0]    o_var;
  logic [rmvmm_pkg::SampleBits-1:0] o_min, o_max;

  rmvmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rmvmm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_count_o (o_count),
    .out_mean_o  (o_mean),
    .out_var_o   (o_var),
    .out_min_o   (o_min),
    .out_max_o   (o_max)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {o_max, o_min, o_var, o_mean, o_count};

endmodule
`default_nettype wire

### design/rmvmm_div.sv
// Restoring divider, one quotient bit per cycle, step count set at start.
// Uses rmvmm_pkg.
`default_nettype none
module rmvmm_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [rmvmm_pkg::SumBits-1:0]     dividend_i,
  input  wire logic [rmvmm_pkg::CountBits-1:0]   divisor_i,
  input  wire logic [rmvmm_pkg::StepBits-1:0]    steps_i,
  output logic                                   done_o,
  output logic [rmvmm_pkg::SumBits-1:0]          quotient_o
);

  logic [rmvmm_pkg::RemBits-1:0]   rem_q, rem_d;
  logic [rmvmm_pkg::SumBits-1:0]   dv_q, dv_d;
  logic [rmvmm_pkg::CountBits-1:0] d_q;
  logic [rmvmm_pkg::StepBits-1:0]  cnt_q, cnt_d;
  logic [rmvmm_pkg::RemBits:0]     shifted;
  logic                            ge;

  always_comb begin
    shifted = {rem_q, dv_q[rmvmm_pkg::SumBits-1]};
    ge      = shifted >= {1'b0, d_q};
    rem_d   = ge ? rmvmm_pkg::RemBits'(shifted - {1'b0, d_q})
                 : rmvmm_pkg::RemBits'(shifted);
    dv_d    = {dv_q[rmvmm_pkg::SumBits-2:0], ge};
    cnt_d   = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= steps_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dv_q  <= dividend_i;
      d_q   <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      dv_q  <= dv_d;
    end
  end

  // last step is in flight; quotient is valid on the next cycle
  assign done_o     = (cnt_q == rmvmm_pkg::StepBits'(1));
  assign quotient_o = dv_q;

endmodule
`default_nettype wire

### design/rmvmm_dp.sv
// Datapath: statistics state, shared 32x32 multiplier, accumulator, divider
// and the output register. Uses rmvmm_pkg and rmvmm_div.
`default_nettype none
module rmvmm_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire rmvmm_pkg::dp_cmd_t                  cmd_i,
  output rmvmm_pkg::dp_status_t                    status_o,
  input  wire logic [rmvmm_pkg::SampleBits-1:0]    sample_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [rmvmm_pkg::CountBits-1:0]          out_count_o,
  output logic [rmvmm_pkg::MeanBits-1:0]           out_mean_o,
  output logic [rmvmm_pkg::VarBits-1:0]            out_var_o,
  output logic [rmvmm_pkg::SampleBits-1:0]         out_min_o,
  output logic [rmvmm_pkg::SampleBits-1:0]         out_max_o
);

  localparam int SB = rmvmm_pkg::SampleBits;
  localparam int MB = rmvmm_pkg::MeanBits;
  localparam int CB = rmvmm_pkg::CountBits;
  localparam int VB = rmvmm_pkg::VarBits;
  localparam int AB = rmvmm_pkg::AccBits;
  localparam int TB = rmvmm_pkg::SumBits;
  localparam int FB = rmvmm_pkg::FracBits;

  logic [CB-1:0]        count_q;
  logic signed [MB-1:0] mean_q, mn_q;
  logic [VB-1:0]        var_q;
  logic signed [SB-1:0] min_q, max_q, x_q;
  logic [AB-1:0]        a_q;
  logic [2*MB-1:0]      prod_q;
  logic [TB-1:0]        t_q;
  logic                 neg_q;

  logic                 ovalid_q;
  logic [CB-1:0]        ocount_q;
  logic [MB-1:0]        omean_q;
  logic [VB-1:0]        ovar_q;
  logic [SB-1:0]        omin_q, omax_q;

  logic [MB-1:0]        mul_a, mul_b;
  logic [2*MB-1:0]      mul_p;
  logic [CB-1:0]        n_new;
  logic signed [MB:0]   diff;
  logic [MB:0]          diff_mag;
  logic [MB-1:0]        mo_mag, mn_mag;
  logic [SB-1:0]        x_mag;
  logic                 div_start, div_done;
  logic [TB-1:0]        div_dvd, quo;
  logic [rmvmm_pkg::StepBits-1:0] div_steps;
  logic [MB:0]          q_signed;
  logic [VB-1:0]        sub;
  logic [VB-1:0]        v_new;
  logic [TB-1:0]        v_diff;
  logic                 out_free;

  always_comb begin
    mo_mag   = mean_q[MB-1] ? MB'(-mean_q) : MB'(mean_q);
    mn_mag   = mn_q[MB-1] ? MB'(-mn_q) : MB'(mn_q);
    x_mag    = x_q[SB-1] ? SB'(-x_q) : SB'(x_q);
    n_new    = (count_q == rmvmm_pkg::CountMax) ? count_q : count_q + 1'b1;
    diff     = (MB+1)'(signed'({x_q, {FB{1'b0}}})) - (MB+1)'(mean_q);
    diff_mag = diff[MB] ? (MB+1)'(-diff) : (MB+1)'(diff);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      rmvmm_pkg::OP_SQ_MO:  begin mul_a = mo_mag; mul_b = mo_mag; end
      rmvmm_pkg::OP_SQ_X:   begin mul_a = MB'(x_mag); mul_b = MB'(x_mag); end
      rmvmm_pkg::OP_MUL_LO: begin mul_a = a_q[MB-1:0]; mul_b = count_q; end
      rmvmm_pkg::OP_MUL_HI: begin mul_a = MB'(a_q[AB-1:MB]); mul_b = count_q; end
      rmvmm_pkg::OP_SQ_MN:  begin mul_a = mn_mag; mul_b = mn_mag; end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = t_q;
    div_steps = rmvmm_pkg::VarSteps;
    if (cmd_i.op == rmvmm_pkg::OP_DIV_MEAN) begin
      div_start = 1'b1;
      div_dvd   = {diff_mag, {(TB-MB-1){1'b0}}};
      div_steps = rmvmm_pkg::MeanSteps;
    end else if (cmd_i.op == rmvmm_pkg::OP_DIV_VAR) begin
      div_start = 1'b1;
    end
  end

  rmvmm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (n_new),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    q_signed = neg_q ? (MB+1)'(-quo[MB:0]) : quo[MB:0];
    sub      = VB'(prod_q >> FB);
    v_diff   = quo - TB'(sub);
    if (count_q == '0 || quo <= TB'(sub)) begin
      v_new = '0;
    end else if (v_diff > TB'(rmvmm_pkg::VarMax)) begin
      v_new = rmvmm_pkg::VarMax;
    end else begin
      v_new = v_diff[VB-1:0];
    end
  end

  assign out_free = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      mean_q   <= '0;
      var_q    <= '0;
      min_q    <= {1'b0, {(SB-1){1'b1}}};
      max_q    <= {1'b1, {(SB-1){1'b0}}};
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.op == rmvmm_pkg::OP_COMMIT) begin
        count_q  <= n_new;
        mean_q   <= mn_q;
        var_q    <= v_new;
        if (x_q < min_q) min_q <= x_q;
        if (x_q > max_q) max_q <= x_q;
        ovalid_q <= 1'b1;
      end else if (ovalid_q && out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      rmvmm_pkg::OP_LOAD:   x_q <= sample_i;
      rmvmm_pkg::OP_SQ_MO:  prod_q <= mul_p;
      rmvmm_pkg::OP_SQ_X: begin
        a_q    <= AB'(var_q) + AB'(prod_q >> FB);
        prod_q <= mul_p;
      end
      rmvmm_pkg::OP_MUL_LO: begin
        t_q    <= TB'(prod_q) << FB;
        prod_q <= mul_p;
      end
      rmvmm_pkg::OP_MUL_HI: begin
        t_q    <= t_q + TB'(prod_q);
        prod_q <= mul_p;
      end
      rmvmm_pkg::OP_ACC_HI:   t_q <= t_q + (TB'(prod_q) << MB);
      rmvmm_pkg::OP_DIV_MEAN: neg_q <= diff[MB];
      rmvmm_pkg::OP_MEAN:     mn_q <= MB'((MB+1)'(mean_q) + q_signed);
      rmvmm_pkg::OP_SQ_MN:    prod_q <= mul_p;
      rmvmm_pkg::OP_COMMIT: begin
        ocount_q <= n_new;
        omean_q  <= mn_q;
        ovar_q   <= v_new;
        omin_q   <= (x_q < min_q) ? x_q : min_q;
        omax_q   <= (x_q > max_q) ? x_q : max_q;
      end
      default: ;
    endcase
  end

  assign status_o    = '{div_done: div_done, out_free: out_free};
  assign out_valid_o = ovalid_q;
  assign out_count_o = ocount_q;
  assign out_mean_o  = omean_q;
  assign out_var_o   = ovar_q;
  assign out_min_o   = omin_q;
  assign out_max_o   = omax_q;

endmodule
`default_nettype wire

### design/rmvmm_ctrl.sv
// Controller: sequences the multiply, accumulate and divide steps per item.
// Uses rmvmm_pkg.
`default_nettype none
module rmvmm_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire rmvmm_pkg::dp_status_t status_i,
  output rmvmm_pkg::dp_cmd_t         cmd_o
);

  rmvmm_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmvmm_pkg::ST_IDLE:       if (in_valid_i) state_d = rmvmm_pkg::ST_SQ_MO;
      rmvmm_pkg::ST_SQ_MO:      state_d = rmvmm_pkg::ST_SQ_X;
      rmvmm_pkg::ST_SQ_X:       state_d = rmvmm_pkg::ST_MUL_LO;
      rmvmm_pkg::ST_MUL_LO:     state_d = rmvmm_pkg::ST_MUL_HI;
      rmvmm_pkg::ST_MUL_HI:     state_d = rmvmm_pkg::ST_ACC_HI;
      rmvmm_pkg::ST_ACC_HI:     state_d = rmvmm_pkg::ST_DIVM_START;
      rmvmm_pkg::ST_DIVM_START: state_d = rmvmm_pkg::ST_DIVM_WAIT;
      rmvmm_pkg::ST_DIVM_WAIT:  if (status_i.div_done) state_d = rmvmm_pkg::ST_MEAN;
      rmvmm_pkg::ST_MEAN:       state_d = rmvmm_pkg::ST_SQ_MN;
      rmvmm_pkg::ST_SQ_MN:      state_d = rmvmm_pkg::ST_DIVV_START;
      rmvmm_pkg::ST_DIVV_START: state_d = rmvmm_pkg::ST_DIVV_WAIT;
      rmvmm_pkg::ST_DIVV_WAIT:  if (status_i.div_done) state_d = rmvmm_pkg::ST_COMMIT;
      rmvmm_pkg::ST_COMMIT:     if (status_i.out_free) state_d = rmvmm_pkg::ST_IDLE;
      default:                  state_d = rmvmm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op       = rmvmm_pkg::OP_NONE;
    cmd_o.in_ready = 1'b0;
    unique case (state_q)
      rmvmm_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) cmd_o.op = rmvmm_pkg::OP_LOAD;
      end
      rmvmm_pkg::ST_SQ_MO:      cmd_o.op = rmvmm_pkg::OP_SQ_MO;
      rmvmm_pkg::ST_SQ_X:       cmd_o.op = rmvmm_pkg::OP_SQ_X;
      rmvmm_pkg::ST_MUL_LO:     cmd_o.op = rmvmm_pkg::OP_MUL_LO;
      rmvmm_pkg::ST_MUL_HI:     cmd_o.op = rmvmm_pkg::OP_MUL_HI;
      rmvmm_pkg::ST_ACC_HI:     cmd_o.op = rmvmm_pkg::OP_ACC_HI;
      rmvmm_pkg::ST_DIVM_START: cmd_o.op = rmvmm_pkg::OP_DIV_MEAN;
      rmvmm_pkg::ST_MEAN:       cmd_o.op = rmvmm_pkg::OP_MEAN;
      rmvmm_pkg::ST_SQ_MN:      cmd_o.op = rmvmm_pkg::OP_SQ_MN;
      rmvmm_pkg::ST_DIVV_START: cmd_o.op = rmvmm_pkg::OP_DIV_VAR;
      rmvmm_pkg::ST_COMMIT:     if (status_i.out_free) cmd_o.op = rmvmm_pkg::OP_COMMIT;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmvmm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire
